[hw/rtl/exu_pkg.sv]
// exu_pkg: shared types and codes for the a64 subset execute unit
// no dependencies; used by the channel interfaces and the top level

package exu_pkg;

  // opcodes in the top 11 bits, and the imms value that marks lsr
  localparam logic [10:0] OP11_HLT  = 11'h6a2;
  localparam logic [10:0] OP11_SUB  = 11'h658;
  localparam logic [10:0] OP11_ADD  = 11'h458;
  localparam logic [10:0] OP11_ADDS = 11'h558;
  localparam logic [10:0] OP11_SUBS = 11'h758;
  localparam logic [10:0] OP11_MUL  = 11'h4d8;
  localparam logic [10:0] OP11_MOVZ = 11'h694;
  localparam logic [10:0] OP11_BR   = 11'h6b0;
  localparam logic [9:0]  OP10_SHF  = 10'h34d;
  localparam logic [8:0]  OP9_LDUR  = 9'h1c2;
  localparam logic [8:0]  OP9_STUR  = 9'h1c0;
  localparam logic [5:0]  IMMS_LSR  = 6'h3f;

  // opcodes in the top 8 bits, and b in the top 6 bits
  localparam logic [7:0] OP8_ADDI  = 8'h91;
  localparam logic [7:0] OP8_SUBI  = 8'hd1;
  localparam logic [7:0] OP8_ADDSI = 8'hb1;
  localparam logic [7:0] OP8_SUBSI = 8'hf1;
  localparam logic [7:0] OP8_AND   = 8'h8a;
  localparam logic [7:0] OP8_ANDS  = 8'hea;
  localparam logic [7:0] OP8_EOR   = 8'hca;
  localparam logic [7:0] OP8_ORR   = 8'haa;
  localparam logic [7:0] OP8_BCOND = 8'h54;
  localparam logic [7:0] OP8_CBZ   = 8'hb4;
  localparam logic [7:0] OP8_CBNZ  = 8'hb5;
  localparam logic [5:0] OP6_B     = 6'h05;

  // condition codes
  localparam logic [4:0] COND_EQ = 5'h00;
  localparam logic [4:0] COND_NE = 5'h01;
  localparam logic [4:0] COND_GE = 5'h0a;
  localparam logic [4:0] COND_LT = 5'h0b;
  localparam logic [4:0] COND_GT = 5'h0c;
  localparam logic [4:0] COND_LE = 5'h0d;

  localparam logic [4:0] REG_ZR = 5'd31;

  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_LOAD  = 2'd1,
    MEM_STORE = 2'd2
  } mem_kind_e;

  typedef struct packed {
    logic [31:0] instr_word;
    logic [63:0] rn_value;
    logic [63:0] rm_value;
    logic [63:0] rt_value;
    logic [63:0] inst_pc;
    logic        predicted_taken;
    logic [63:0] predicted_target;
  } in_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic        write_back;
    logic [4:0]  dest_reg;
    logic [1:0]  mem_kind;
    logic [3:0]  access_bytes;
    logic [63:0] mem_address;
    logic        branch_taken;
    logic        redirect;
    logic [63:0] redirect_pc;
    logic        halt;
    logic        flag_n;
    logic        flag_z;
  } out_t;

endpackage

[hw/rtl/exu_ifs.sv]
// exu_ifs: valid/ready channel interfaces for instruction and result words
// depends on exu_pkg for the payload types

interface exu_in_if;
  logic         valid;
  logic         ready;
  exu_pkg::in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface exu_out_if;
  logic          valid;
  logic          ready;
  exu_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/a64_subset_execute_unit.sv]
// a64_subset_execute_unit: decode and execute of an a64 integer subset
// depends on exu_pkg and the channel interfaces in exu_ifs
//
//   channel  dir  handshake     word
//   in_i     in   valid/ready   instruction, operands, pc, prediction
//   out_o    out  valid/ready   writeback, memory request, branch, flags
//
// one word per cycle sustained while out_o is not stalled
// stages: input register, decode/execute register, result register
// the 64-bit multiply is split into 32x32 partial products summed in stage three
// reset clears the stage valids and the n/z flags
// a stalled output holds every stage that is full; empty stages still fill

module a64_subset_execute_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  exu_in_if.sink       in_i,
  exu_out_if.source    out_o
);

  typedef struct packed {
    logic [63:0] alu_res;
    logic        is_mul;
    logic [63:0] pp_ll;
    logic [31:0] pp_lh;
    logic [31:0] pp_hl;
    logic        write_back;
    logic [4:0]  dest_reg;
    logic [1:0]  mem_kind;
    logic [3:0]  access_bytes;
    logic [63:0] mem_address;
    logic        branch_taken;
    logic        redirect;
    logic [63:0] redirect_pc;
    logic        halt;
    logic        flag_n;
    logic        flag_z;
  } ex_t;

  // stage valids and flow control
  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;

  exu_pkg::in_t  s1_q;
  ex_t           s2_d, s2_q;
  exu_pkg::out_t s3_d, s3_q;

  // n in bit 1, z in bit 0
  logic [1:0] flags_d, flags_q;

  assign adv3 = !v3_q || out_o.ready;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  assign in_i.ready  = adv1;
  assign out_o.valid = v3_q;
  assign out_o.data  = s3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      flags_q <= 2'b00;
    end else begin
      if (adv1) v1_q <= in_i.valid;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      // flags move only when an instruction enters execute, keeping program order
      if (adv2 && v1_q) flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_i.valid) s1_q <= in_i.data;
    if (adv2 && v1_q) s2_q <= s2_d;
    if (adv3 && v2_q) s3_q <= s3_d;
  end

  // decode and execute
  logic [31:0] w;
  logic [10:0] op11;
  logic [7:0]  op8;
  logic [4:0]  rd;
  logic [63:0] rn, rm, rt, pc;
  logic [63:0] imm12, imm9, off19, off26;
  logic [5:0]  immr, imms;
  logic [63:0] add_rr, sub_rr, add_ri, sub_ri, and_rr;
  logic [63:0] pc_next, target;
  logic        is_branch, taken;
  logic        cond_ok;

  always_comb begin
    w     = s1_q.instr_word;
    op11  = w[31:21];
    op8   = w[31:24];
    rd    = w[4:0];
    rn    = s1_q.rn_value;
    rm    = s1_q.rm_value;
    rt    = s1_q.rt_value;
    pc    = s1_q.inst_pc;
    imm12 = {52'd0, w[21:10]};
    imm9  = {{55{w[20]}}, w[20:12]};
    off19 = {{43{w[23]}}, w[23:5], 2'b00};
    off26 = {{36{w[25]}}, w[25:0], 2'b00};
    immr  = w[21:16];
    imms  = w[15:10];
    add_rr = rn + rm;
    sub_rr = rn - rm;
    add_ri = rn + imm12;
    sub_ri = rn - imm12;
    and_rr = rn & rm;
    pc_next = pc + 64'd4;

    case (rd)
      exu_pkg::COND_EQ: cond_ok = flags_q[0];
      exu_pkg::COND_NE: cond_ok = !flags_q[0];
      exu_pkg::COND_GE: cond_ok = !flags_q[1];
      exu_pkg::COND_LT: cond_ok = flags_q[1];
      exu_pkg::COND_GT: cond_ok = !flags_q[1] && !flags_q[0];
      exu_pkg::COND_LE: cond_ok = flags_q[1] || flags_q[0];
      default:          cond_ok = 1'b0;
    endcase

    s2_d      = '0;
    s2_d.pp_ll = {32'd0, rn[31:0]} * {32'd0, rm[31:0]};
    s2_d.pp_lh = rn[31:0] * rm[63:32];
    s2_d.pp_hl = rn[63:32] * rm[31:0];
    flags_d   = flags_q;
    is_branch = 1'b0;
    taken     = 1'b0;
    target    = '0;

    if (op11 == exu_pkg::OP11_HLT) begin
      s2_d.halt = 1'b1;
    end else if (op11 == exu_pkg::OP11_ADD) begin
      s2_d.alu_res = add_rr; s2_d.write_back = 1'b1;
    end else if (op11 == exu_pkg::OP11_SUB) begin
      s2_d.alu_res = sub_rr; s2_d.write_back = 1'b1;
    end else if (op11 == exu_pkg::OP11_ADDS) begin
      s2_d.alu_res = add_rr; s2_d.write_back = 1'b1;
      flags_d = {add_rr[63], add_rr == '0};
    end else if (op11 == exu_pkg::OP11_SUBS) begin
      s2_d.alu_res = (rd == exu_pkg::REG_ZR) ? '0 : sub_rr; s2_d.write_back = 1'b1;
      flags_d = {sub_rr[63], sub_rr == '0};
    end else if (op11 == exu_pkg::OP11_MUL) begin
      s2_d.is_mul = 1'b1; s2_d.write_back = 1'b1;
    end else if (op11 == exu_pkg::OP11_MOVZ) begin
      s2_d.alu_res = {48'd0, w[20:5]}; s2_d.write_back = 1'b1;
    end else if (op11 == exu_pkg::OP11_BR) begin
      is_branch = 1'b1; taken = 1'b1; target = rn;
    end else if (op11[10:1] == exu_pkg::OP10_SHF) begin
      s2_d.alu_res = (imms == exu_pkg::IMMS_LSR) ? (rn >> immr) : (rn << (6'd0 - immr));
      s2_d.write_back = 1'b1;
    end else if (op11[8:0] == exu_pkg::OP9_LDUR || op11[8:0] == exu_pkg::OP9_STUR) begin
      s2_d.mem_address  = rn + imm9;
      s2_d.access_bytes = 4'd1 << op11[10:9];
      if (op11[8:0] == exu_pkg::OP9_LDUR) begin
        s2_d.mem_kind = exu_pkg::MEM_LOAD; s2_d.write_back = 1'b1;
      end else begin
        s2_d.mem_kind = exu_pkg::MEM_STORE; s2_d.alu_res = rt;
      end
    end else if (op8 == exu_pkg::OP8_ADDI) begin
      s2_d.alu_res = add_ri; s2_d.write_back = 1'b1;
    end else if (op8 == exu_pkg::OP8_SUBI) begin
      s2_d.alu_res = sub_ri; s2_d.write_back = 1'b1;
    end else if (op8 == exu_pkg::OP8_ADDSI) begin
      s2_d.alu_res = add_ri; s2_d.write_back = 1'b1;
      flags_d = {add_ri[63], add_ri == '0};
    end else if (op8 == exu_pkg::OP8_SUBSI) begin
      s2_d.alu_res = (rd == exu_pkg::REG_ZR) ? '0 : sub_ri; s2_d.write_back = 1'b1;
      flags_d = {sub_ri[63], sub_ri == '0};
    end else if (op8 == exu_pkg::OP8_AND) begin
      s2_d.alu_res = and_rr; s2_d.write_back = 1'b1;
    end else if (op8 == exu_pkg::OP8_ANDS) begin
      s2_d.alu_res = and_rr; s2_d.write_back = 1'b1;
      flags_d = {and_rr[63], and_rr == '0};
    end else if (op8 == exu_pkg::OP8_EOR) begin
      s2_d.alu_res = rn ^ rm; s2_d.write_back = 1'b1;
    end else if (op8 == exu_pkg::OP8_ORR) begin
      s2_d.alu_res = rn | rm; s2_d.write_back = 1'b1;
    end else if (op8 == exu_pkg::OP8_BCOND || op8 == exu_pkg::OP8_CBZ ||
                 op8 == exu_pkg::OP8_CBNZ) begin
      is_branch = 1'b1;
      target    = pc + off19;
      if (op8 == exu_pkg::OP8_BCOND) taken = cond_ok;
      else if (op8 == exu_pkg::OP8_CBZ) taken = (rt == '0);
      else taken = (rt != '0);
    end else if (w[31:26] == exu_pkg::OP6_B) begin
      is_branch = 1'b1; taken = 1'b1; target = pc + off26;
    end

    s2_d.dest_reg     = s2_d.write_back ? rd : '0;
    s2_d.branch_taken = taken;
    // mispredict check against the fetch stage's next pc
    if (is_branch && taken) begin
      if (!s1_q.predicted_taken || s1_q.predicted_target != target) begin
        s2_d.redirect = 1'b1; s2_d.redirect_pc = target;
      end
    end else if (is_branch && s1_q.predicted_taken && s1_q.predicted_target != pc_next) begin
      s2_d.redirect = 1'b1; s2_d.redirect_pc = pc_next;
    end
    s2_d.flag_n = flags_d[1];
    s2_d.flag_z = flags_d[0];
  end

  // final stage: finish the multiply and pack the result word
  logic [31:0] mul_hi;

  always_comb begin
    mul_hi = s2_q.pp_ll[63:32] + s2_q.pp_lh + s2_q.pp_hl;
    s3_d.result_value = s2_q.is_mul ? {mul_hi, s2_q.pp_ll[31:0]} : s2_q.alu_res;
    s3_d.write_back   = s2_q.write_back;
    s3_d.dest_reg     = s2_q.dest_reg;
    s3_d.mem_kind     = s2_q.mem_kind;
    s3_d.access_bytes = s2_q.access_bytes;
    s3_d.mem_address  = s2_q.mem_address;
    s3_d.branch_taken = s2_q.branch_taken;
    s3_d.redirect     = s2_q.redirect;
    s3_d.redirect_pc  = s2_q.redirect_pc;
    s3_d.halt         = s2_q.halt;
    s3_d.flag_n       = s2_q.flag_n;
    s3_d.flag_z       = s2_q.flag_z;
  end

`ifndef NO_ASSERTIONS
  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && s3_q.halt) |-> (!s3_q.write_back && s3_q.mem_kind == exu_pkg::MEM_NONE))
    else $error("halt word carries writeback or memory request");
  a_store_no_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && s3_q.mem_kind == exu_pkg::MEM_STORE) |-> !s3_q.write_back)
    else $error("store word requests writeback");
  a_redirect_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !s3_q.redirect) |-> (s3_q.redirect_pc == '0))
    else $error("redirect pc set without redirect");
  a_flags_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(adv2 && v1_q) |=> $stable(flags_q))
    else $error("flags changed with no instruction entering execute");
`endif

endmodule

[tb/sv/exu_checker.sv]
// exu_checker: watches both channels of the execute unit, predicts every result word
// depends on exu_pkg and the channel interfaces in exu_ifs

module exu_checker (
  input  logic clk_i,
  input  logic rst_ni,
  exu_in_if    in_i,
  exu_out_if   out_o,
  output int   fail_count_o,
  output int   pending_o,
  output int   words_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [1:0]    nz_flags;
  exu_pkg::out_t result_q[$];

  function automatic logic [63:0] sext(logic [63:0] v, int bits);
    logic [63:0] r;
    r = v;
    for (int i = bits; i < 64; i++) r[i] = v[bits-1];
    return r;
  endfunction

  function automatic logic cond_ok(logic [4:0] c, logic [1:0] f);
    case (c)
      exu_pkg::COND_EQ: return f[0];
      exu_pkg::COND_NE: return !f[0];
      exu_pkg::COND_GE: return !f[1];
      exu_pkg::COND_LT: return f[1];
      exu_pkg::COND_GT: return !f[1] && !f[0];
      exu_pkg::COND_LE: return f[1] || f[0];
      default: return 1'b0;
    endcase
  endfunction

  // computes one result word and updates the flag copy
  task automatic execute_word(input exu_pkg::in_t x, output exu_pkg::out_t o);
    logic [31:0] w;
    logic [10:0] op11;
    logic [7:0]  op8;
    logic [4:0]  rd;
    logic [63:0] imm12, res, tgt;
    logic        wb, br, tk, setf;
    logic [5:0]  immr;
    w = x.instr_word; op11 = w[31:21]; op8 = w[31:24]; rd = w[4:0];
    imm12 = {52'd0, w[21:10]};
    o = '0; res = '0; wb = 1'b0; br = 1'b0; tk = 1'b0; setf = 1'b0; tgt = '0;
    if (op11 == exu_pkg::OP11_HLT) o.halt = 1'b1;
    else if (op11 == exu_pkg::OP11_ADD) begin
      res = x.rn_value + x.rm_value; wb = 1'b1;
    end else if (op11 == exu_pkg::OP11_SUB) begin
      res = x.rn_value - x.rm_value; wb = 1'b1;
    end else if (op11 == exu_pkg::OP11_ADDS) begin
      res = x.rn_value + x.rm_value; wb = 1'b1; setf = 1'b1;
    end else if (op11 == exu_pkg::OP11_SUBS) begin
      res = x.rn_value - x.rm_value; wb = 1'b1; setf = 1'b1;
    end else if (op11 == exu_pkg::OP11_MUL) begin
      res = x.rn_value * x.rm_value; wb = 1'b1;
    end else if (op11 == exu_pkg::OP11_MOVZ) begin
      res = {48'd0, w[20:5]}; wb = 1'b1;
    end else if (op11 == exu_pkg::OP11_BR) begin
      br = 1'b1; tk = 1'b1; tgt = x.rn_value;
    end else if (op11[10:1] == exu_pkg::OP10_SHF) begin
      immr = w[21:16];
      if (w[15:10] == exu_pkg::IMMS_LSR) res = x.rn_value >> immr;
      else res = x.rn_value << 6'(7'd64 - immr);
      wb = 1'b1;
    end else if (op11[8:0] == exu_pkg::OP9_LDUR || op11[8:0] == exu_pkg::OP9_STUR) begin
      o.mem_address = x.rn_value + sext({55'd0, w[20:12]}, 9);
      o.access_bytes = 4'(1 << op11[10:9]);
      if (op11[8:0] == exu_pkg::OP9_LDUR) begin
        o.mem_kind = exu_pkg::MEM_LOAD; wb = 1'b1;
      end else begin
        o.mem_kind = exu_pkg::MEM_STORE; res = x.rt_value;
      end
    end else if (op8 == exu_pkg::OP8_ADDI) begin
      res = x.rn_value + imm12; wb = 1'b1;
    end else if (op8 == exu_pkg::OP8_SUBI) begin
      res = x.rn_value - imm12; wb = 1'b1;
    end else if (op8 == exu_pkg::OP8_ADDSI) begin
      res = x.rn_value + imm12; wb = 1'b1; setf = 1'b1;
    end else if (op8 == exu_pkg::OP8_SUBSI) begin
      res = x.rn_value - imm12; wb = 1'b1; setf = 1'b1;
    end else if (op8 == exu_pkg::OP8_AND) begin
      res = x.rn_value & x.rm_value; wb = 1'b1;
    end else if (op8 == exu_pkg::OP8_ANDS) begin
      res = x.rn_value & x.rm_value; wb = 1'b1; setf = 1'b1;
    end else if (op8 == exu_pkg::OP8_EOR) begin
      res = x.rn_value ^ x.rm_value; wb = 1'b1;
    end else if (op8 == exu_pkg::OP8_ORR) begin
      res = x.rn_value | x.rm_value; wb = 1'b1;
    end else if (op8 == exu_pkg::OP8_BCOND || op8 == exu_pkg::OP8_CBZ ||
                 op8 == exu_pkg::OP8_CBNZ) begin
      br = 1'b1;
      tgt = x.inst_pc + (sext({45'd0, w[23:5]}, 19) << 2);
      if (op8 == exu_pkg::OP8_BCOND) tk = cond_ok(rd, nz_flags);
      else if (op8 == exu_pkg::OP8_CBZ) tk = (x.rt_value == 0);
      else tk = (x.rt_value != 0);
    end else if (w[31:26] == exu_pkg::OP6_B) begin
      br = 1'b1; tk = 1'b1; tgt = x.inst_pc + (sext({38'd0, w[25:0]}, 26) << 2);
    end
    if (setf) begin
      nz_flags = {res[63], res == 0};
      // compare into the zero register drops the value
      if ((op11 == exu_pkg::OP11_SUBS || op8 == exu_pkg::OP8_SUBSI) &&
          rd == exu_pkg::REG_ZR) res = '0;
    end
    if (br) begin
      if (tk) begin
        if (!x.predicted_taken || x.predicted_target != tgt) begin
          o.redirect = 1'b1; o.redirect_pc = tgt;
        end
      end else if (x.predicted_taken && x.predicted_target != x.inst_pc + 64'd4) begin
        o.redirect = 1'b1; o.redirect_pc = x.inst_pc + 64'd4;
      end
    end
    o.result_value = res;
    o.write_back = wb;
    o.dest_reg = wb ? rd : 5'd0;
    o.branch_taken = tk;
    o.flag_n = nz_flags[1];
    o.flag_z = nz_flags[0];
  endtask

  assign pending_o = result_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    exu_pkg::out_t e, a;
    if (!rst_ni) begin
      nz_flags = '0;
      fail_count_o <= 0;
      words_seen_o <= 0;
      result_q.delete();
    end else begin
      if (in_i.valid && in_i.ready) begin
        execute_word(in_i.data, e);
        result_q.push_back(e);
      end
      if (out_o.valid && out_o.ready) begin
        a = out_o.data;
        words_seen_o <= words_seen_o + 1;
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, a);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = result_q.pop_front();
          if (a !== e) begin
            $display("%0t: mismatch expected %h actual %h", $time, e, a);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

[tb/sv/a64_subset_execute_unit_tb.sv]
// a64_subset_execute_unit_tb: stimulus and verdict for the execute unit
// depends on exu_pkg, exu_ifs, the rtl top and exu_checker

module a64_subset_execute_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 0;
  logic rst_ni = 0;
  int   fail_count, pending, words_seen;
  int   sent = 0;

  exu_in_if  in_ch();
  exu_out_if out_ch();

  a64_subset_execute_unit u_top (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch));
  exu_checker u_chk (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch),
                     .fail_count_o(fail_count), .pending_o(pending), .words_seen_o(words_seen));

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // mostly no gap, often a short one, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic logic [63:0] rand64();
    int r;
    r = $urandom_range(9);
    case (r)
      0: return '0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'(($urandom_range(15)));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // builds an instruction word for one of the supported opcodes, random fields, or now and then raw noise
  function automatic logic [31:0] rand_instr();
    logic [31:0] w;
    int k;
    w = $urandom;
    k = $urandom_range(25);
    case (k)
      0: w[31:21] = exu_pkg::OP11_ADD;   1: w[31:21] = exu_pkg::OP11_SUB;
      2: w[31:21] = exu_pkg::OP11_ADDS;  3: w[31:21] = exu_pkg::OP11_SUBS;
      4: w[31:21] = exu_pkg::OP11_MUL;   5: w[31:21] = exu_pkg::OP11_MOVZ;
      6: w[31:21] = exu_pkg::OP11_BR;    7: w[31:21] = exu_pkg::OP11_HLT;
      8: begin
        w[31:22] = exu_pkg::OP10_SHF;
        if ($urandom_range(1)) w[15:10] = exu_pkg::IMMS_LSR;
      end
      9: w[29:21] = exu_pkg::OP9_LDUR;   10: w[29:21] = exu_pkg::OP9_STUR;
      11: w[31:24] = exu_pkg::OP8_ADDI;  12: w[31:24] = exu_pkg::OP8_SUBI;
      13: w[31:24] = exu_pkg::OP8_ADDSI; 14: w[31:24] = exu_pkg::OP8_SUBSI;
      15: w[31:24] = exu_pkg::OP8_AND;   16: w[31:24] = exu_pkg::OP8_ANDS;
      17: w[31:24] = exu_pkg::OP8_EOR;   18: w[31:24] = exu_pkg::OP8_ORR;
      19, 20: w[31:24] = exu_pkg::OP8_BCOND;
      21: w[31:24] = exu_pkg::OP8_CBZ;   22: w[31:24] = exu_pkg::OP8_CBNZ;
      23: w[31:26] = exu_pkg::OP6_B;
      default: ;  // raw noise, mostly unknown encodings
    endcase
    if (k inside {3, 14} && $urandom_range(2) == 0) w[4:0] = exu_pkg::REG_ZR;
    return w;
  endfunction

  // valid stays high across back to back words and drops only for a gap
  task automatic send_word(input exu_pkg::in_t x);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_ch.data  <= x;
    in_ch.valid <= 1'b1;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic send_rand(input logic [31:0] w);
    exu_pkg::in_t x;
    logic [63:0] tgt;
    x.instr_word = w;
    x.rn_value = rand64();
    x.rm_value = rand64();
    x.rt_value = rand64();
    x.inst_pc = {$urandom, $urandom};
    // give the predictor a real chance of being right
    tgt = x.inst_pc + 64'd4;
    case ($urandom_range(3))
      0: x.predicted_target = tgt;
      1: x.predicted_target = x.inst_pc + ({{38{w[25]}}, w[25:0]} << 2);
      2: x.predicted_target = x.inst_pc + ({{45{w[23]}}, w[23:5]} << 2);
      default: x.predicted_target = {$urandom, $urandom};
    endcase
    if (w[31:21] == exu_pkg::OP11_BR && $urandom_range(1)) x.predicted_target = x.rn_value;
    x.predicted_taken = 1'($urandom_range(1));
    send_word(x);
  endtask

  // result side stalls
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_ch.ready <= (gap_len() == 0);
    end
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [4:0] conds[6];
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    conds = '{exu_pkg::COND_EQ, exu_pkg::COND_NE, exu_pkg::COND_GE,
              exu_pkg::COND_LT, exu_pkg::COND_GT, exu_pkg::COND_LE};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: flag setting extremes, edge encodings, then every condition code
    send_rand({exu_pkg::OP11_SUBS, 5'd0, 6'd0, 5'd0, exu_pkg::REG_ZR});
    send_rand({exu_pkg::OP8_ADDSI, 2'b00, 12'hfff, 5'd1, 5'd2});
    send_rand({exu_pkg::OP11_HLT, 21'd0});
    send_rand({exu_pkg::OP11_MOVZ, 16'hffff, 5'd31});
    send_rand({exu_pkg::OP10_SHF, 6'd0, 6'd0, 5'd1, 5'd1});
    send_rand({exu_pkg::OP10_SHF, 6'd63, exu_pkg::IMMS_LSR, 5'd1, 5'd1});
    send_rand({2'b11, exu_pkg::OP9_LDUR, 9'h100, 2'd0, 5'd3, 5'd4});
    send_rand({2'b00, exu_pkg::OP9_STUR, 9'h0ff, 2'd0, 5'd3, 5'd4});
    send_rand({exu_pkg::OP6_B, 26'h3ff_ffff});
    send_rand({exu_pkg::OP6_B, 26'h1ff_ffff});
    send_rand(32'd0);
    send_rand(32'hffff_ffff);
    foreach (conds[i]) begin
      send_rand({exu_pkg::OP8_ANDS, 24'h0});
      send_rand({exu_pkg::OP8_BCOND, 19'h40000, conds[i]});
    end
    send_rand({exu_pkg::OP8_BCOND, 19'h7ffff, 5'h1e});

    repeat (900) send_rand(rand_instr());
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("sent %0d instruction words over all opcodes, %0d results checked",
             sent, words_seen);
    $display("random operands, predictions and stalls on both channels");
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

[sim.f]
hw/rtl/exu_pkg.sv
hw/rtl/exu_ifs.sv
hw/rtl/a64_subset_execute_unit.sv
tb/sv/exu_checker.sv
tb/sv/a64_subset_execute_unit_tb.sv
